// File: sv/hcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the Huffman code builder: request and result
// payloads, command and status codes, controller states and micro-ops.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int HCB_MAX_LEAVES    = 256;
  localparam int HCB_MAX_CODE_BITS = 32;
  localparam int WEIGHT_W          = 24;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_LONG    = 3'd4;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  symbol;
    logic [15:0] frequency;
    logic        last;
  } hcb_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] code_bits;
    logic [7:0]  code_length;
  } hcb_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LD_CHK, S_LD_LAST, S_BLD_START, S_BLD_LOOP,
    S_POP_RD, S_POP_CAP, S_SHIFT_RD, S_SHIFT_WR, S_RB_START, S_SIFT_RD,
    S_SIFT_ELEM, S_LVL, S_LVL_L, S_LVL_R, S_DECIDE, S_SIFT_END,
    S_SUM_NODE, S_LINK_F, S_LINK_S, S_PUSH, S_ONE_NODE, S_ONE_LINK,
    S_SET_ROOT, S_VISIT, S_ASC_P, S_ASC_C, S_UP_P, S_UP_R, S_FIN
  } state_t;

  // where a pop or heap rebuild returns to
  typedef enum logic [2:0] {
    CTX_LOAD, CTX_POP_F, CTX_POP_S, CTX_PUSH, CTX_ROOT_ONE, CTX_ROOT
  } ctx_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_ACCEPT, OP_LD_CLR, OP_SET_FULL, OP_LD_NODE, OP_SET_EMPTY,
    OP_CLEAR_ALL, OP_POP_RD, OP_CAP_F, OP_CAP_S, OP_SHIFT_RD, OP_SHIFT_WR,
    OP_POP_END, OP_RB_INIT, OP_SIFT_RD, OP_SIFT_ELEM, OP_LVL_END, OP_LVL_RDL,
    OP_CAP_L, OP_CAP_R, OP_DECIDE, OP_MID_DEC, OP_SUM_NODE, OP_LINK_F,
    OP_LINK_S, OP_PUSH, OP_ONE_NODE, OP_ONE_LINK, OP_SET_ROOT, OP_Q_START,
    OP_NOT_FOUND, OP_Q_DOWN, OP_Q_PAR, OP_ASC_P, OP_Q_LEFT, OP_Q_UP,
    OP_U_RDR, OP_U_STEP, OP_TOO_LONG, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } hcb_ctrl_t;

  typedef struct packed {
    logic in_valid;
    cmd_t cmd;
    logic last;
    logic built;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_full;
    logic shift_done;
    logic no_child;
    logic r_in;
    logic pick_top;
    logic mid_zero;
    logic sym_hit;
    logic has_child;
    logic par_nl;
    logic asc_left;
    logic n_full;
    logic out_free;
  } hcb_flags_t;

endpackage
`default_nettype wire

// File: sv/hcb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_if
// Valid/ready channels of the Huffman code builder: request and result.
// ----------------------------------------------------------------------------
interface hcb_req_if import hcb_pkg::*; ();
  logic     valid;
  logic     ready;
  hcb_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hcb_rsp_if import hcb_pkg::*; ();
  logic     valid;
  logic     ready;
  hcb_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/hcb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/hcb_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_controller
// Sequencer for load, heap rebuild, tree build and code query.
// ----------------------------------------------------------------------------
module hcb_controller import hcb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  hcb_flags_t flags,
  output hcb_ctrl_t  ctrl
);

  state_t state, state_next;
  ctx_t   ctx, ctx_next;
  state_t ret_state;
  ctx_t   ret_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctx   <= CTX_LOAD;
    end else begin
      state <= state_next;
      ctx   <= ctx_next;
    end
  end

  always_comb begin
    ret_ctx = ctx;
    unique case (ctx)
      CTX_LOAD:     ret_state = S_LD_LAST;
      CTX_POP_F: begin
        ret_state = S_POP_RD;
        ret_ctx   = CTX_POP_S;
      end
      CTX_POP_S:    ret_state = S_SUM_NODE;
      CTX_PUSH:     ret_state = S_BLD_LOOP;
      CTX_ROOT_ONE: ret_state = S_ONE_NODE;
      CTX_ROOT:     ret_state = S_SET_ROOT;
      default:      ret_state = S_FIN;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    ctx_next   = ctx;
    unique case (state)
      S_IDLE:      if (flags.in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (flags.cmd)
          CMD_LOAD:  state_next = S_LD_CHK;
          CMD_QUERY: state_next = flags.built ? S_VISIT : S_FIN;
          default:   state_next = S_FIN;
        endcase
      end
      S_LD_CHK: begin
        if (flags.cnt_full) begin
          state_next = S_LD_LAST;
        end else begin
          state_next = S_RB_START;
          ctx_next   = CTX_LOAD;
        end
      end
      S_LD_LAST:   state_next = flags.last ? S_BLD_START : S_FIN;
      S_BLD_START: begin
        if (flags.cnt_zero) begin
          state_next = S_FIN;
        end else if (flags.cnt_one) begin
          state_next = S_POP_RD;
          ctx_next   = CTX_ROOT_ONE;
        end else begin
          state_next = S_BLD_LOOP;
        end
      end
      S_BLD_LOOP: begin
        state_next = S_POP_RD;
        ctx_next   = (flags.cnt_zero || flags.cnt_one) ? CTX_ROOT : CTX_POP_F;
      end
      S_POP_RD:    state_next = S_POP_CAP;
      S_POP_CAP:   state_next = S_SHIFT_RD;
      S_SHIFT_RD:  state_next = flags.shift_done ? S_RB_START : S_SHIFT_WR;
      S_SHIFT_WR:  state_next = S_SHIFT_RD;
      S_RB_START: begin
        if (flags.cnt_zero) begin
          state_next = ret_state;
          ctx_next   = ret_ctx;
        end else begin
          state_next = S_SIFT_RD;
        end
      end
      S_SIFT_RD:   state_next = S_SIFT_ELEM;
      S_SIFT_ELEM: state_next = S_LVL;
      S_LVL:       state_next = flags.no_child ? S_SIFT_END : S_LVL_L;
      S_LVL_L:     state_next = flags.r_in ? S_LVL_R : S_DECIDE;
      S_LVL_R:     state_next = S_DECIDE;
      S_DECIDE:    state_next = flags.pick_top ? S_SIFT_END : S_LVL;
      S_SIFT_END: begin
        if (flags.mid_zero) begin
          state_next = ret_state;
          ctx_next   = ret_ctx;
        end else begin
          state_next = S_SIFT_RD;
        end
      end
      S_SUM_NODE:  state_next = S_LINK_F;
      S_LINK_F:    state_next = S_LINK_S;
      S_LINK_S:    state_next = S_PUSH;
      S_PUSH: begin
        state_next = S_RB_START;
        ctx_next   = CTX_PUSH;
      end
      S_ONE_NODE:  state_next = S_ONE_LINK;
      S_ONE_LINK:  state_next = S_FIN;
      S_SET_ROOT:  state_next = S_FIN;
      S_VISIT: begin
        if (flags.sym_hit) state_next = S_UP_P;
        else if (flags.has_child) state_next = S_VISIT;
        else state_next = S_ASC_P;
      end
      S_ASC_P:     state_next = flags.par_nl ? S_FIN : S_ASC_C;
      S_ASC_C:     state_next = flags.asc_left ? S_VISIT : S_ASC_P;
      S_UP_P:      state_next = (flags.par_nl || flags.n_full) ? S_FIN : S_UP_R;
      S_UP_R:      state_next = S_UP_P;
      S_FIN:       if (flags.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl.op       = OP_NONE;
    ctrl.in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (flags.in_valid) ctrl.op = OP_ACCEPT;
      end
      S_DISPATCH: begin
        unique case (flags.cmd)
          CMD_LOAD:  ctrl.op = OP_LD_CLR;
          CMD_QUERY: ctrl.op = flags.built ? OP_Q_START : OP_NOT_FOUND;
          CMD_CLEAR: ctrl.op = OP_CLEAR_ALL;
          default:   ctrl.op = OP_NONE;
        endcase
      end
      S_LD_CHK:    ctrl.op = flags.cnt_full ? OP_SET_FULL : OP_LD_NODE;
      S_BLD_START: if (flags.cnt_zero) ctrl.op = OP_SET_EMPTY;
      S_POP_RD:    ctrl.op = OP_POP_RD;
      S_POP_CAP:   ctrl.op = (ctx == CTX_POP_S) ? OP_CAP_S : OP_CAP_F;
      S_SHIFT_RD:  ctrl.op = flags.shift_done ? OP_POP_END : OP_SHIFT_RD;
      S_SHIFT_WR:  ctrl.op = OP_SHIFT_WR;
      S_RB_START:  if (!flags.cnt_zero) ctrl.op = OP_RB_INIT;
      S_SIFT_RD:   ctrl.op = OP_SIFT_RD;
      S_SIFT_ELEM: ctrl.op = OP_SIFT_ELEM;
      S_LVL:       ctrl.op = flags.no_child ? OP_LVL_END : OP_LVL_RDL;
      S_LVL_L:     ctrl.op = OP_CAP_L;
      S_LVL_R:     ctrl.op = OP_CAP_R;
      S_DECIDE:    ctrl.op = OP_DECIDE;
      S_SIFT_END:  if (!flags.mid_zero) ctrl.op = OP_MID_DEC;
      S_SUM_NODE:  ctrl.op = OP_SUM_NODE;
      S_LINK_F:    ctrl.op = OP_LINK_F;
      S_LINK_S:    ctrl.op = OP_LINK_S;
      S_PUSH:      ctrl.op = OP_PUSH;
      S_ONE_NODE:  ctrl.op = OP_ONE_NODE;
      S_ONE_LINK:  ctrl.op = OP_ONE_LINK;
      S_SET_ROOT:  ctrl.op = OP_SET_ROOT;
      S_VISIT: begin
        if (flags.sym_hit) ctrl.op = OP_Q_PAR;
        else if (flags.has_child) ctrl.op = OP_Q_DOWN;
        else ctrl.op = OP_Q_PAR;
      end
      S_ASC_P:     ctrl.op = flags.par_nl ? OP_NOT_FOUND : OP_ASC_P;
      S_ASC_C:     ctrl.op = flags.asc_left ? OP_Q_LEFT : OP_Q_UP;
      S_UP_P: begin
        if (flags.par_nl) ctrl.op = OP_NONE;
        else if (flags.n_full) ctrl.op = OP_TOO_LONG;
        else ctrl.op = OP_U_RDR;
      end
      S_UP_R:      ctrl.op = OP_U_STEP;
      S_FIN:       if (flags.out_free) ctrl.op = OP_EMIT;
      default:     ctrl.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/hcb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_datapath
// Heap and node stores, heap sift unit, tree walk and result register.
// ----------------------------------------------------------------------------
module hcb_datapath import hcb_pkg::*; #(
  parameter int MAX_LEAVES    = HCB_MAX_LEAVES,
  parameter int MAX_CODE_BITS = HCB_MAX_CODE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  hcb_ctrl_t  ctrl,
  output hcb_flags_t flags,
  input  logic       in_valid,
  input  hcb_req_t   req,
  output logic       out_valid,
  input  logic       out_ready,
  output hcb_rsp_t   rsp
);

  localparam int NODE_DEPTH = 2 * MAX_LEAVES - 1;
  localparam int NODE_W     = $clog2(2 * MAX_LEAVES);
  localparam int SLOT_W     = $clog2(MAX_LEAVES);
  localparam int CNT_W      = $clog2(MAX_LEAVES + 1);
  localparam int HE_W       = NODE_W + WEIGHT_W;
  localparam int LEN_W      = $clog2(MAX_CODE_BITS + 1);
  localparam int IDX_W      = $clog2(MAX_CODE_BITS);
  localparam logic [NODE_W-1:0] NL = {NODE_W{1'b1}};

  // request
  cmd_t        cmd_q;
  logic [7:0]  sym_q;
  logic [15:0] freq_q;
  logic        last_q;
  logic [2:0]  status_q;

  // heap and tree control
  logic [CNT_W-1:0]  heap_count;
  logic [NODE_W-1:0] node_count;
  logic              built;
  logic [NODE_W-1:0] root;
  logic [CNT_W-1:0]  i;
  logic [SLOT_W-1:0] high, mid, top;
  logic [NODE_W-1:0] elem_n, l_n, r_n, f_n, s_n;
  logic [WEIGHT_W-1:0] elem_w, l_w, r_w, f_w, s_w, sum_w;
  logic              r_ok;

  // walk
  logic [NODE_W-1:0]        cur, par;
  logic [MAX_CODE_BITS-1:0] code;
  logic [LEN_W-1:0]         n;

  // memories
  logic              h_we;
  logic [SLOT_W-1:0] h_waddr, h_raddr;
  logic [HE_W-1:0]   h_wdata, h_rdata;
  logic              n_we, p_we;
  logic [NODE_W-1:0] n_waddr, p_waddr, na;
  logic [7:0]        sym_wdata, sym_rd;
  logic [NODE_W-1:0] left_wdata, right_wdata, p_wdata, left_rd, right_rd, par_rd;

  logic [NODE_W-1:0]   h_node;
  logic [WEIGHT_W-1:0] h_w;
  logic [SLOT_W+1:0]   l_idx, r_idx, high_x;
  logic [CNT_W-1:0]    hc_m1, i_dec;
  logic                pick_l, pick_r, pick_top;
  logic [HE_W-1:0]     child;
  logic [SLOT_W-1:0]   child_idx;
  logic                right_nl, left_nl, right_is_cur;
  logic [MAX_CODE_BITS+31:0] code_x;
  logic [LEN_W+7:0]          len_x;

  // last interior slot of a heap whose top index is h
  function automatic logic [SLOT_W-1:0] i_mid(input logic [SLOT_W-1:0] h);
    logic [SLOT_W-1:0] d;
    d = h - SLOT_W'(1);
    return d >> 1;
  endfunction

  assign h_node       = h_rdata[HE_W-1:WEIGHT_W];
  assign h_w          = h_rdata[WEIGHT_W-1:0];
  assign l_idx        = {1'b0, top, 1'b1};
  assign r_idx        = l_idx + (SLOT_W + 2)'(1);
  assign high_x       = {2'b00, high};
  assign hc_m1        = heap_count - CNT_W'(1);
  assign i_dec        = i - CNT_W'(1);
  assign pick_l       = l_w < elem_w;
  assign pick_r       = r_ok && (r_w < (pick_l ? l_w : elem_w));
  assign pick_top     = !pick_l && !pick_r;
  assign child        = pick_r ? {r_n, r_w} : {l_n, l_w};
  assign child_idx    = pick_r ? r_idx[SLOT_W-1:0] : l_idx[SLOT_W-1:0];
  assign right_nl     = right_rd == NL;
  assign left_nl      = left_rd == NL;
  assign right_is_cur = right_rd == cur;
  assign code_x       = {32'b0, code};
  assign len_x        = {8'b0, n};

  assign flags.in_valid   = in_valid;
  assign flags.cmd        = cmd_q;
  assign flags.last       = last_q;
  assign flags.built      = built;
  assign flags.cnt_zero   = heap_count == '0;
  assign flags.cnt_one    = heap_count == CNT_W'(1);
  assign flags.cnt_full   = heap_count >= CNT_W'(MAX_LEAVES);
  assign flags.shift_done = i >= heap_count;
  assign flags.no_child   = l_idx > high_x;
  assign flags.r_in       = r_idx <= high_x;
  assign flags.pick_top   = pick_top;
  assign flags.mid_zero   = mid == '0;
  assign flags.sym_hit    = sym_rd == sym_q;
  assign flags.has_child  = !right_nl || !left_nl;
  assign flags.par_nl     = par_rd == NL;
  assign flags.asc_left   = right_is_cur && !left_nl;
  assign flags.n_full     = n >= LEN_W'(MAX_CODE_BITS);
  assign flags.out_free   = !out_valid || out_ready;

  // heap port
  always_comb begin
    h_we    = 1'b0;
    h_waddr = top;
    h_wdata = {elem_n, elem_w};
    h_raddr = '0;
    case (ctrl.op)
      OP_LD_NODE: begin
        h_we    = 1'b1;
        h_waddr = heap_count[SLOT_W-1:0];
        h_wdata = {node_count, {(WEIGHT_W - 16){1'b0}}, freq_q};
      end
      OP_PUSH: begin
        h_we    = 1'b1;
        h_waddr = heap_count[SLOT_W-1:0];
        h_wdata = {cur, sum_w};
      end
      OP_SHIFT_WR: begin
        h_we    = 1'b1;
        h_waddr = i_dec[SLOT_W-1:0];
        h_wdata = h_rdata;
      end
      OP_LVL_END: h_we = 1'b1;
      OP_DECIDE: begin
        h_we    = 1'b1;
        h_wdata = pick_top ? {elem_n, elem_w} : child;
      end
      OP_SHIFT_RD: h_raddr = i[SLOT_W-1:0];
      OP_SIFT_RD:  h_raddr = mid;
      OP_LVL_RDL:  h_raddr = l_idx[SLOT_W-1:0];
      OP_CAP_L:    h_raddr = r_idx[SLOT_W-1:0];
      default:     h_raddr = '0;
    endcase
  end

  // node ports
  always_comb begin
    n_we        = 1'b0;
    p_we        = 1'b0;
    n_waddr     = node_count;
    p_waddr     = node_count;
    sym_wdata   = 8'd0;
    left_wdata  = f_n;
    right_wdata = s_n;
    p_wdata     = NL;
    case (ctrl.op)
      OP_LD_NODE: begin
        n_we        = 1'b1;
        p_we        = 1'b1;
        sym_wdata   = sym_q;
        left_wdata  = NL;
        right_wdata = NL;
      end
      OP_SUM_NODE: begin
        n_we = 1'b1;
        p_we = 1'b1;
      end
      OP_ONE_NODE: begin
        n_we        = 1'b1;
        p_we        = 1'b1;
        right_wdata = NL;
      end
      OP_LINK_F, OP_ONE_LINK: begin
        p_we    = 1'b1;
        p_waddr = f_n;
        p_wdata = cur;
      end
      OP_LINK_S: begin
        p_we    = 1'b1;
        p_waddr = s_n;
        p_wdata = cur;
      end
      default: n_we = 1'b0;
    endcase
  end

  always_comb begin
    case (ctrl.op)
      OP_Q_START:          na = root;
      OP_Q_DOWN:           na = right_nl ? left_rd : right_rd;
      OP_ASC_P, OP_U_RDR:  na = par_rd;
      OP_Q_LEFT:           na = left_rd;
      OP_Q_UP, OP_U_STEP:  na = par;
      default:             na = cur;
    endcase
  end

  hcb_ram #(.WIDTH(HE_W), .DEPTH(MAX_LEAVES)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  hcb_ram #(.WIDTH(8), .DEPTH(NODE_DEPTH)) u_sym (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(sym_wdata),
    .raddr(na), .rdata(sym_rd)
  );

  hcb_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_left (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(left_wdata),
    .raddr(na), .rdata(left_rd)
  );

  hcb_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_right (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(right_wdata),
    .raddr(na), .rdata(right_rd)
  );

  hcb_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(na), .rdata(par_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_count <= '0;
      node_count <= '0;
      built      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.op == OP_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (ctrl.op)
        OP_LD_CLR: begin
          if (built) begin
            heap_count <= '0;
            node_count <= '0;
            built      <= 1'b0;
          end
        end
        OP_CLEAR_ALL: begin
          heap_count <= '0;
          node_count <= '0;
          built      <= 1'b0;
        end
        OP_LD_NODE: begin
          heap_count <= heap_count + CNT_W'(1);
          node_count <= node_count + NODE_W'(1);
        end
        OP_POP_END:  heap_count <= hc_m1;
        OP_PUSH:     heap_count <= heap_count + CNT_W'(1);
        OP_SUM_NODE, OP_ONE_NODE: node_count <= node_count + NODE_W'(1);
        OP_ONE_LINK, OP_SET_ROOT: built <= 1'b1;
        default: built <= built;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_ACCEPT: begin
        cmd_q    <= cmd_t'(req.cmd);
        sym_q    <= req.symbol;
        freq_q   <= req.frequency;
        last_q   <= req.last;
        status_q <= ST_OK;
        code     <= '0;
        n        <= '0;
      end
      OP_SET_FULL:  status_q <= ST_FULL;
      OP_SET_EMPTY: if (status_q == ST_OK) status_q <= ST_EMPTY;
      OP_NOT_FOUND: status_q <= ST_MISSING;
      OP_TOO_LONG:  status_q <= ST_LONG;
      OP_CAP_F: begin
        f_n <= h_node;
        f_w <= h_w;
        i   <= CNT_W'(1);
      end
      OP_CAP_S: begin
        s_n <= h_node;
        s_w <= h_w;
        i   <= CNT_W'(1);
      end
      OP_SHIFT_WR: i <= i + CNT_W'(1);
      OP_RB_INIT: begin
        high <= hc_m1[SLOT_W-1:0];
        mid  <= (hc_m1 == '0) ? '0 : i_mid(hc_m1[SLOT_W-1:0]);
      end
      OP_SIFT_RD: top <= mid;
      OP_SIFT_ELEM: begin
        elem_n <= h_node;
        elem_w <= h_w;
      end
      OP_CAP_L: begin
        l_n  <= h_node;
        l_w  <= h_w;
        r_ok <= flags.r_in;
      end
      OP_CAP_R: begin
        r_n <= h_node;
        r_w <= h_w;
      end
      OP_DECIDE:  if (!pick_top) top <= child_idx;
      OP_MID_DEC: mid <= mid - SLOT_W'(1);
      OP_SUM_NODE: begin
        cur   <= node_count;
        sum_w <= f_w + s_w;
      end
      OP_ONE_NODE: begin
        cur  <= node_count;
        root <= node_count;
      end
      OP_SET_ROOT: root <= f_n;
      OP_Q_START:  cur <= root;
      OP_Q_DOWN:   cur <= right_nl ? left_rd : right_rd;
      OP_ASC_P, OP_U_RDR: par <= par_rd;
      OP_Q_LEFT:   cur <= left_rd;
      OP_Q_UP:     cur <= par;
      OP_U_STEP: begin
        if (right_is_cur) code[n[IDX_W-1:0]] <= 1'b1;
        n   <= n + LEN_W'(1);
        cur <= par;
      end
      OP_EMIT: begin
        rsp.status      <= status_q;
        rsp.code_bits   <= (status_q == ST_OK) ? code_x[31:0] : 32'd0;
        rsp.code_length <= (status_q == ST_OK) ? len_x[7:0] : 8'd0;
      end
      default: r_ok <= r_ok;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/huffman_code_builder.sv
`default_nettype none
// Load: each leaf stored is followed by a rebuild of all interior slots of the heap.
// Build on n leaves: n-1 merges, each two pops (with a shift of the slots) and a
//   push, each followed by a full heap rebuild.
// Query: walks the tree, then climbs to the root for the code bits, over one RAM port.
// One request at a time. Reset clears counts and tree; RAMs are not cleared.
// ----------------------------------------------------------------------------
// huffman_code_builder
// Huffman code builder: leaf load into a min-heap, tree build, code query.
// ----------------------------------------------------------------------------
module huffman_code_builder import hcb_pkg::*; #(
  parameter int MAX_LEAVES    = HCB_MAX_LEAVES,
  parameter int MAX_CODE_BITS = HCB_MAX_CODE_BITS
) (
  input logic        clk,
  input logic        rst,
  hcb_req_if.sink    request,
  hcb_rsp_if.source  result
);

  hcb_ctrl_t  ctrl;
  hcb_flags_t flags;

  assign request.ready = ctrl.in_ready;

  hcb_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  hcb_datapath #(
    .MAX_LEAVES    (MAX_LEAVES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .flags     (flags),
    .in_valid  (request.valid),
    .req       (request.payload),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .rsp       (result.payload)
  );

endmodule
`default_nettype wire

// File: dv/hcb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_checker
// Watches the request and result channels of the Huffman code builder, keeps
// its own heap and tree, predicts each answer and compares it field by field.
// ----------------------------------------------------------------------------
module hcb_checker import hcb_pkg::*; (
  input  logic clk,
  input  logic rst,
  hcb_req_if   req_mon,
  hcb_rsp_if   rsp_mon,
  output int   errors,
  output int   pending,
  output int   answers_seen
);

  localparam int NODES = 2 * HCB_MAX_LEAVES - 1;
  localparam logic [9:0] NO_LINK = 10'h3FF;

  logic [9:0]  heap_slot [HCB_MAX_LEAVES];
  int          heap_len;
  logic [23:0] weight [NODES];
  logic [7:0]  sym_of [NODES];
  logic [9:0]  left_of [NODES];
  logic [9:0]  right_of [NODES];
  logic [9:0]  parent_of [NODES];
  int          node_len;
  logic [9:0]  root;
  bit          tree_ready;
  hcb_rsp_t    answers_due [$];

  function automatic void wipe();
    for (int i = 0; i < HCB_MAX_LEAVES; i++) heap_slot[i] = '0;
    for (int i = 0; i < NODES; i++) begin
      weight[i] = '0; sym_of[i] = '0; left_of[i] = '0;
      right_of[i] = '0; parent_of[i] = '0;
    end
    heap_len = 0;
    node_len = 0;
    root = NO_LINK;
    tree_ready = 0;
  endfunction

  function automatic logic [9:0] alloc(logic [7:0] s, logic [23:0] w,
                                       logic [9:0] l, logic [9:0] r);
    int i;
    i = node_len;
    if (i >= NODES) return NO_LINK;
    sym_of[i] = s; weight[i] = w; left_of[i] = l; right_of[i] = r;
    parent_of[i] = NO_LINK;
    node_len = i + 1;
    return 10'(i);
  endfunction

  function automatic logic [23:0] slot_weight(int slot);
    logic [9:0] n;
    n = heap_slot[slot];
    return (n < NODES) ? weight[n] : 24'd0;
  endfunction

  function automatic void sift(int top, int high);
    int l, r, pick;
    logic [9:0] t;
    while (2 * top + 1 <= high) begin
      l = 2 * top + 1; r = 2 * top + 2; pick = top;
      if (slot_weight(l) < slot_weight(pick)) pick = l;
      if (r <= high && slot_weight(r) < slot_weight(pick)) pick = r;
      if (pick == top) break;
      t = heap_slot[top]; heap_slot[top] = heap_slot[pick]; heap_slot[pick] = t;
      top = pick;
    end
  endfunction

  function automatic void reheap();
    int high, mid;
    if (heap_len == 0) return;
    high = heap_len - 1;
    mid = high ? (high - 1) / 2 : 0;
    forever begin
      sift(mid, high);
      if (mid == 0) break;
      mid--;
    end
  endfunction

  function automatic void push(logic [9:0] n);
    if (heap_len >= HCB_MAX_LEAVES) return;
    heap_slot[heap_len] = n;
    heap_len++;
    if (heap_len > 1) reheap();
  endfunction

  function automatic logic [9:0] pop();
    logic [9:0] f;
    if (heap_len == 0) return NO_LINK;
    f = heap_slot[0];
    for (int i = 1; i < heap_len; i++) heap_slot[i-1] = heap_slot[i];
    heap_len--;
    reheap();
    return f;
  endfunction

  function automatic void tie(logic [9:0] child, logic [9:0] par);
    if (child < NODES) parent_of[child] = par;
  endfunction

  function automatic logic [2:0] build();
    logic [9:0] f, s, n;
    logic [23:0] w;
    if (heap_len == 0) return ST_EMPTY;
    if (heap_len == 1) begin
      f = pop();
      n = alloc(8'd0, 24'd0, f, NO_LINK);
      tie(f, n);
      root = n;
    end else begin
      while (heap_len > 1) begin
        f = pop();
        s = pop();
        w = ((f < NODES) ? weight[f] : 24'd0) + ((s < NODES) ? weight[s] : 24'd0);
        n = alloc(8'd0, w, f, s);
        tie(f, n);
        tie(s, n);
        push(n);
      end
      root = pop();
    end
    tree_ready = root < NODES;
    return ST_OK;
  endfunction

  function automatic hcb_rsp_t lookup(logic [7:0] s);
    hcb_rsp_t a;
    logic [9:0] stack [NODES];
    logic [9:0] hit, t, cur, p;
    int sp, n, guard;
    a = '0;
    a.status = ST_MISSING;
    if (!tree_ready || root >= NODES) return a;
    sp = 0; hit = NO_LINK;
    stack[sp++] = root;
    while (sp > 0) begin
      t = stack[--sp];
      if (t >= NODES) continue;
      if (sym_of[t] == s) begin hit = t; break; end
      if (left_of[t] != NO_LINK && sp < NODES) stack[sp++] = left_of[t];
      if (right_of[t] != NO_LINK && sp < NODES) stack[sp++] = right_of[t];
    end
    if (hit == NO_LINK) return a;
    n = 0; guard = 0; cur = hit;
    while (cur < NODES && parent_of[cur] != NO_LINK && guard < NODES) begin
      p = parent_of[cur];
      if (p >= NODES) break;
      if (n >= HCB_MAX_CODE_BITS) begin
        a.status = ST_LONG;
        return a;
      end
      if (right_of[p] == cur) a.code_bits[n] = 1'b1;
      n++;
      cur = p;
      guard++;
    end
    a.status = ST_OK;
    a.code_length = 8'(n);
    return a;
  endfunction

  function automatic hcb_rsp_t predict_answer(hcb_req_t r);
    hcb_rsp_t a;
    logic [2:0] b;
    a = '0;
    case (cmd_t'(r.cmd))
      CMD_LOAD: begin
        if (tree_ready) wipe();
        if (heap_len >= HCB_MAX_LEAVES) a.status = ST_FULL;
        else push(alloc(r.symbol, 24'(r.frequency), NO_LINK, NO_LINK));
        if (r.last) begin
          b = build();
          if (a.status == ST_OK) a.status = b;
        end
      end
      CMD_QUERY: a = lookup(r.symbol);
      CMD_CLEAR: wipe();
      default: ;
    endcase
    return a;
  endfunction

  assign pending = answers_due.size();

  always @(posedge clk) begin
    hcb_rsp_t want, got;
    if (rst) begin
      wipe();
      answers_due.delete();
      errors <= 0;
      answers_seen <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready)
        answers_due.push_back(predict_answer(req_mon.payload));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.payload;
        answers_seen <= answers_seen + 1;
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result status=%0d bits=%h len=%0d",
                   $time, got.status, got.code_bits, got.code_length);
          errors <= errors + 1;
        end else begin
          want = answers_due[0];
          answers_due.delete(0);
          if (got.status !== want.status || got.code_bits !== want.code_bits ||
              got.code_length !== want.code_length) begin
            $display("%0t: mismatch expected status=%0d bits=%h len=%0d, got %0d %h %0d",
                     $time, want.status, want.code_bits, want.code_length,
                     got.status, got.code_bits, got.code_length);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: dv/huffman_code_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder_tb
// Drives loads, builds, queries and clears into the code builder under random
// idling on both channels; a checker beside the block predicts every answer.
// ----------------------------------------------------------------------------
module huffman_code_builder_tb import hcb_pkg::*; ();

  localparam int CYCLE_LIMIT = 40_000_000;

  logic clk = 0;
  logic rst = 1;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   errors, pending, answers_seen;
  int   cycles = 0;
  int   sent = 0;

  hcb_req_if req ();
  hcb_rsp_if rsp ();

  huffman_code_builder dut (.clk(clk), .rst(rst), .request(req.sink), .result(rsp.source));

  hcb_checker chk (
    .clk(clk), .rst(rst), .req_mon(req), .rsp_mon(rsp),
    .errors(errors), .pending(pending), .answers_seen(answers_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("huffman_code_builder_tb: done, errors");
      $finish;
    end
  end

  task automatic send(cmd_t c, logic [7:0] s, logic [15:0] f, logic l);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1;
    req.payload <= '{cmd: c, symbol: s, frequency: f, last: l};
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one tree: n leaves, then queries on loaded and random symbols
  task automatic tree_round(int n);
    logic [7:0] syms [$];
    logic [15:0] f;
    int q;
    for (int i = 0; i < n; i++) begin
      syms.push_back(8'($urandom));
      case ($urandom_range(3))
        0: f = 16'($urandom_range(3));
        1: f = 16'hFFFF - 16'($urandom_range(3));
        default: f = 16'($urandom);
      endcase
      send(CMD_LOAD, syms[i], f, i == n - 1);
    end
    q = $urandom_range(2, 2 * n + 2);
    for (int i = 0; i < q; i++) begin
      case ($urandom_range(5))
        0: send(CMD_QUERY, 8'($urandom), 16'($urandom), 1'($urandom));
        1: send(CMD_QUERY, 8'd0, 16'($urandom), 1'($urandom));
        default: send(CMD_QUERY, syms[$urandom_range(n - 1)], 16'($urandom), 1'($urandom));
      endcase
    end
  endtask

  task automatic random_phase(int items);
    int start;
    start = sent;
    while (sent - start < items) begin
      case ($urandom_range(9))
        0: send(CMD_CLEAR, 8'($urandom), 16'($urandom), 1'($urandom));
        1: send(cmd_t'($urandom_range(3)), 8'($urandom), 16'($urandom), 1'($urandom));
        2: tree_round($urandom_range(13, 40));
        default: tree_round($urandom_range(1, 12));
      endcase
    end
  endtask

  initial begin
    req.valid = 0;
    req.payload = '0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: unbuilt query, single leaf, extremes, unknown command, clear
    send(CMD_QUERY, 8'd7, 16'd0, 1'b0);
    send(CMD_LOAD, 8'd5, 16'hFFFF, 1'b1);
    send(CMD_QUERY, 8'd5, 16'd0, 1'b0);
    send(CMD_QUERY, 8'd0, 16'd0, 1'b0);
    send(CMD_QUERY, 8'd9, 16'd0, 1'b0);
    send(CMD_LOAD, 8'd255, 16'd0, 1'b0);
    send(CMD_LOAD, 8'd0, 16'hFFFF, 1'b0);
    send(CMD_LOAD, 8'd170, 16'd0, 1'b1);
    send(CMD_QUERY, 8'd255, 16'hFFFF, 1'b1);
    send(CMD_QUERY, 8'd0, 16'd0, 1'b0);
    send(CMD_QUERY, 8'd170, 16'd0, 1'b0);
    send(CMD_NOP, 8'd255, 16'hFFFF, 1'b1);
    send(CMD_CLEAR, 8'd0, 16'd0, 1'b0);
    send(CMD_QUERY, 8'd255, 16'd0, 1'b0);
    drain();

    // table full: every slot held, then one more leaf dropped
    for (int i = 0; i < HCB_MAX_LEAVES; i++)
      send(CMD_LOAD, 8'(i), 16'($urandom), 1'b0);
    send(CMD_LOAD, 8'd77, 16'd1, 1'b0);
    send(CMD_CLEAR, 8'd0, 16'd0, 1'b0);
    send(CMD_QUERY, 8'd77, 16'd0, 1'b0);
    drain();

    send_idle = 35; recv_idle = 57;
    random_phase(150);
    drain();
    send_idle = 57; recv_idle = 35;
    random_phase(150);
    drain();
    send_idle = 0; recv_idle = 0;
    random_phase(150);
    drain();

    repeat (200) @(posedge clk);
    $display("covered %0d requests, %0d results: loads, builds, queries, clears, full table",
             sent, answers_seen);
    if (errors == 0 && pending == 0)
      $display("huffman_code_builder_tb: done, clean");
    else
      $display("huffman_code_builder_tb: done, errors");
    $finish;
  end

endmodule

// File: files.f
sv/hcb_pkg.sv
sv/hcb_if.sv
sv/hcb_ram.sv
sv/hcb_controller.sv
sv/hcb_datapath.sv
sv/huffman_code_builder.sv
dv/hcb_checker.sv
dv/huffman_code_builder_tb.sv
